// ----- sv/level_sensor_average_debounce_macros.svh -----
// Assertion macros for the level sensor average and debounce block.
`ifndef LEVEL_SENSOR_AVERAGE_DEBOUNCE_MACROS_SVH
`define LEVEL_SENSOR_AVERAGE_DEBOUNCE_MACROS_SVH

`ifndef ASSERT_OFF
`define LSAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define LSAD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LSAD_ASSERT(label, clk, rst_n, prop, msg)
`define LSAD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- sv/lsad_pkg.sv -----
// Shared types and constants of the level sensor average and debounce block.
package lsad_pkg;

  localparam int unsigned WindowLength = 8;
  localparam int unsigned LevelW       = 12;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned DebounceW    = 16;
  localparam int unsigned LevelMax     = 4095;
  localparam int unsigned SumW         = $clog2(WindowLength * LevelMax + 1);
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [LevelW-1:0]    ThresholdReset = LevelW'(2048);
  localparam logic [DebounceW-1:0] DebounceReset  = DebounceW'(500);

  typedef enum logic [CfgIdxW-1:0] {
    RegLevelThreshold = 1'b0,
    RegDebounceTime   = 1'b1
  } lsad_reg_e;

  typedef struct packed {
    logic [LevelW-1:0] sample;
    logic [TimeW-1:0]  now_ms;
  } lsad_in_t;

  typedef struct packed {
    logic              changed;
    logic              water_present;
    logic [LevelW-1:0] filtered_level;
  } lsad_out_t;

  typedef struct packed {
    logic [LevelW-1:0]    level_threshold;
    logic [DebounceW-1:0] debounce_time;
  } lsad_cfg_t;

  typedef struct packed {
    logic changed;
    logic water_present;
  } lsad_status_t;

endpackage

// ----- sv/level_sensor_average_debounce.sv -----
// Top level: beat registers, configuration registers, window and debounce.
//
// Takes one sensor beat per clock cycle while the output side is not stalled,
// and returns one result beat for each, in order, via the input and result registers.
// Each beat shifts its sample into an eight-entry window kept with a running
// sum; the truncated mean is compared against level_threshold (strictly
// greater means water present) and a new level is accepted once it has
// persisted for debounce_time milliseconds of the beat's now_ms time. The
// window sum and the debounce state both close their update loop in their own
// registers, allowing one beat per cycle without a stall. Configuration writes take
// effect at once and are meant to happen only while no beat is in flight.
`include "level_sensor_average_debounce_macros.svh"
module level_sensor_average_debounce import lsad_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsad_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsad_out_t           out_data_o
);

  lsad_cfg_t         cfg_q;
  lsad_in_t          in_q;
  logic              in_vld_q;
  lsad_out_t         out_q;
  logic              out_vld_q;
  logic              move;
  logic [LevelW-1:0] mean;
  lsad_status_t      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_threshold <= ThresholdReset;
      cfg_q.debounce_time   <= DebounceReset;
    end else if (cfg_we_i) begin
      unique case (lsad_reg_e'(cfg_idx_i))
        RegLevelThreshold: cfg_q.level_threshold <= cfg_wdata_i[LevelW-1:0];
        RegDebounceTime:   cfg_q.debounce_time   <= cfg_wdata_i[DebounceW-1:0];
        default: ;
      endcase
    end
  end

  // advance a beat from the input register into the result register
  assign move       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  lsad_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (move),
    .sample_i (in_q.sample),
    .mean_o   (mean)
  );

  lsad_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (move),
    .mean_i   (mean),
    .now_i    (in_q.now_ms),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.changed        <= status.changed;
      out_q.water_present  <= status.water_present;
      out_q.filtered_level <= mean;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `LSAD_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i),
    "input stalled while pipeline can advance")
  `LSAD_ASSERT(a_move_fills_output, clk_i, rst_ni,
    move |=> out_vld_q,
    "advanced beat did not reach result register")
  `LSAD_ASSERT(a_drain_empties_output, clk_i, rst_ni,
    (out_vld_q && out_ready_i && !move) |=> !out_vld_q,
    "result beat repeated after delivery")
  `LSAD_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> (!in_vld_q && !out_vld_q),
    "beat registers hold data after reset")

endmodule

// ----- sv/lsad_window.sv -----
// Sample window shift line with running sum and truncated mean.
module lsad_window import lsad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [LevelW-1:0] sample_i,
  output logic [LevelW-1:0] mean_o
);

  logic [LevelW-1:0] window_q [WindowLength];
  logic [LevelW-1:0] window_d [WindowLength];
  logic [SumW-1:0]   sum_q, sum_d;

  always_comb begin
    for (int k = 0; k < int'(WindowLength) - 1; k++) begin
      window_d[k] = window_q[k+1];
    end
    window_d[WindowLength-1] = sample_i;
  end

  assign sum_d  = sum_q - SumW'(window_q[0]) + SumW'(sample_i);
  assign mean_o = LevelW'(sum_d / WindowLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int k = 0; k < int'(WindowLength); k++) begin
        window_q[k] <= '0;
      end
    end else if (en_i) begin
      sum_q    <= sum_d;
      window_q <= window_d;
    end
  end

endmodule

// ----- sv/lsad_debounce.sv -----
// Threshold compare and time debounce of the filtered level.
module lsad_debounce import lsad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [LevelW-1:0] mean_i,
  input  logic [TimeW-1:0]  now_i,
  input  lsad_cfg_t         cfg_i,
  output lsad_status_t      status_o
);

  logic             accepted_q, accepted_d;
  logic             pending_q, pending_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             level;
  logic [TimeW-1:0] elapsed;
  logic             changed;

  assign level   = mean_i > cfg_i.level_threshold;
  assign elapsed = now_i - start_q;

  always_comb begin
    accepted_d = accepted_q;
    pending_d  = pending_q;
    start_d    = start_q;
    changed    = 1'b0;
    if (level == pending_q) begin
      if (level != accepted_q && elapsed >= TimeW'(cfg_i.debounce_time)) begin
        accepted_d = level;
        changed    = 1'b1;
      end
    end else begin
      pending_d = level;
      start_d   = now_i;
    end
  end

  assign status_o.changed       = changed;
  assign status_o.water_present = accepted_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_q <= 1'b0;
      pending_q  <= 1'b0;
      start_q    <= '0;
    end else if (en_i) begin
      accepted_q <= accepted_d;
      pending_q  <= pending_d;
      start_q    <= start_d;
    end
  end

endmodule

// ----- bench/level_sensor_average_debounce_tb.sv -----
// Testbench for the level sensor block: directed table, then random beats checked by a predictor.
module level_sensor_average_debounce_tb;
  import lsad_pkg::*;

  localparam int unsigned RandomBeats = 1800;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;

  typedef enum logic {RowBeat, RowWrite} row_kind_e;
  typedef enum logic [1:0] {ReadyAlways, ReadyCoin, ReadySparse, ReadyToggle} ready_mode_e;

  typedef struct {
    row_kind_e           kind;
    lsad_reg_e           reg_sel;
    logic [CfgDataW-1:0] wdata;
    lsad_in_t            beat;
    bit                  typed;
    lsad_out_t           want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  lsad_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  lsad_out_t           out_data_o;

  logic [LevelW-1:0]    hist [WindowLength];
  logic                 held_level;
  logic                 candidate_level;
  logic [TimeW-1:0]     candidate_since;
  logic [LevelW-1:0]    threshold;
  logic [DebounceW-1:0] hold_ms;

  lsad_out_t   level_reports_q[$];
  int unsigned burst_left;
  int unsigned beats_sent;
  int unsigned directed_beats;
  int unsigned writes_done;
  int unsigned results_checked;
  int unsigned changes_seen;
  int unsigned error_count;
  int unsigned cycle_count;

  level_sensor_average_debounce dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
  end

  function automatic lsad_out_t average_and_debounce(input lsad_in_t beat);
    logic [SumW-1:0]   sum;
    logic [LevelW-1:0] mean;
    logic              level;
    lsad_out_t         res;
    for (int k = 0; k < WindowLength - 1; k++) hist[k] = hist[k+1];
    hist[WindowLength-1] = beat.sample;
    sum = '0;
    foreach (hist[j]) sum += SumW'(hist[j]);
    mean = LevelW'(sum / WindowLength);
    level = mean > threshold;
    res = '0;
    if (level != candidate_level) begin
      candidate_level = level;
      candidate_since = beat.now_ms;
    end else if (level != held_level &&
                 TimeW'(beat.now_ms - candidate_since) >= TimeW'(hold_ms)) begin
      held_level = level;
      res.changed = 1'b1;
    end
    res.water_present = held_level;
    res.filtered_level = mean;
    return res;
  endfunction

  function automatic stim_row_t beat_row(input logic [LevelW-1:0] smp,
                                         input logic [TimeW-1:0] t);
    stim_row_t r;
    r = '{kind: RowBeat, reg_sel: RegLevelThreshold, wdata: '0, beat: '0,
          typed: 1'b0, want: '0};
    r.beat.sample = smp;
    r.beat.now_ms = t;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [LevelW-1:0] smp,
                                          input logic [TimeW-1:0] t, input logic chg,
                                          input logic wet, input logic [LevelW-1:0] lvl);
    stim_row_t r;
    r = beat_row(smp, t);
    r.typed = 1'b1;
    r.want.changed = chg;
    r.want.water_present = wet;
    r.want.filtered_level = lvl;
    return r;
  endfunction

  function automatic stim_row_t write_row(input lsad_reg_e sel,
                                          input logic [CfgDataW-1:0] data);
    stim_row_t r;
    r = beat_row('0, '0);
    r.kind = RowWrite;
    r.reg_sel = sel;
    r.wdata = data;
    return r;
  endfunction

  task automatic send_beat(input lsad_in_t beat, input bit typed, input lsad_out_t want);
    int unsigned gap;
    lsad_out_t   predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    beats_sent++;
    predicted = average_and_debounce(beat);
    level_reports_q.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input lsad_reg_e sel, input logic [CfgDataW-1:0] data);
    in_valid_i <= 1'b0;
    while (level_reports_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      RegLevelThreshold: threshold = data[LevelW-1:0];
      RegDebounceTime:   hold_ms = data[DebounceW-1:0];
    endcase
    writes_done++;
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("[%0d] %s", cycle_count, msg);
  endtask

  task automatic check_result(input lsad_out_t got);
    lsad_out_t want;
    results_checked++;
    if (got.changed) changes_seen++;
    if (level_reports_q.size() == 0) begin
      note_error($sformatf("result beat with nothing pending: changed=%0b wet=%0b level=%0d",
                           got.changed, got.water_present, got.filtered_level));
      return;
    end
    want = level_reports_q.pop_front();
    if (got.changed !== want.changed)
      note_error($sformatf("changed: expected %0b, got %0b", want.changed, got.changed));
    if (got.water_present !== want.water_present)
      note_error($sformatf("water_present: expected %0b, got %0b",
                           want.water_present, got.water_present));
    if (got.filtered_level !== want.filtered_level)
      note_error($sformatf("filtered_level: expected %0d, got %0d",
                           want.filtered_level, got.filtered_level));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
  end

  initial begin : receiver
    ready_mode_e mode;
    int unsigned mode_left;
    mode = ReadyAlways;
    mode_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(4, 64);
      end
      mode_left--;
      case (mode)
        ReadyAlways: out_ready_i <= 1'b1;
        ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        ReadySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
        ReadyToggle: out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    stim_row_t            rows[$];
    lsad_in_t             beat;
    logic [TimeW-1:0]     now;
    logic [LevelW-1:0]    thr;
    logic [DebounceW-1:0] hold;
    logic [CfgDataW-1:0]  wdata;
    int                   aim;
    int                   smp;
    int unsigned          seg_left;
    int unsigned          phase_left;
    int unsigned          step_max;
    int unsigned          target_beats;

    cfg_we_i = 1'b0;
    cfg_idx_i = RegLevelThreshold;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    foreach (hist[j]) hist[j] = '0;
    held_level = 1'b0;
    candidate_level = 1'b0;
    candidate_since = '0;
    threshold = ThresholdReset;
    hold_ms = DebounceReset;

    // rise with a wrapping clock, then a fall with zero hold, then boundary and max hold
    rows.push_back(typed_row(12'd0,    32'h0000_0000, 1'b0, 1'b0, 12'd0));
    rows.push_back(typed_row(12'd4095, 32'hFFFF_FE00, 1'b0, 1'b0, 12'd511));
    rows.push_back(beat_row(12'd4095,  32'hFFFF_FE10));
    rows.push_back(beat_row(12'd4095,  32'hFFFF_FE20));
    rows.push_back(beat_row(12'd4095,  32'hFFFF_FE30));
    rows.push_back(beat_row(12'd4095,  32'hFFFF_FF00));
    rows.push_back(beat_row(12'd4095,  32'hFFFF_FF80));
    rows.push_back(beat_row(12'd4095,  32'h0000_00E3));
    rows.push_back(typed_row(12'd4095, 32'h0000_00F3, 1'b0, 1'b0, 12'd4095));
    rows.push_back(typed_row(12'd4095, 32'h0000_00F4, 1'b1, 1'b1, 12'd4095));
    rows.push_back(typed_row(12'd4095, 32'h0000_00F5, 1'b0, 1'b1, 12'd4095));
    rows.push_back(write_row(RegLevelThreshold, 16'hFFFF));
    rows.push_back(write_row(RegDebounceTime,   16'h0000));
    rows.push_back(typed_row(12'd4095, 32'h0000_1000, 1'b0, 1'b1, 12'd4095));
    rows.push_back(typed_row(12'd4095, 32'h0000_1000, 1'b1, 1'b0, 12'd4095));
    rows.push_back(write_row(RegLevelThreshold, 16'hF000));
    rows.push_back(beat_row(12'd1,     32'h0000_1001));
    rows.push_back(beat_row(12'd0,     32'h0000_1001));
    rows.push_back(write_row(RegLevelThreshold, 16'h0BFF));
    rows.push_back(write_row(RegDebounceTime,   16'hFFFF));
    rows.push_back(beat_row(12'd4095,  32'h0000_2000));
    rows.push_back(beat_row(12'd4095,  32'h0001_1FFE));
    rows.push_back(beat_row(12'd4095,  32'h0001_1FFF));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == RowWrite) write_reg(rows[i].reg_sel, rows[i].wdata);
      else send_beat(rows[i].beat, rows[i].typed, rows[i].want);
    end
    directed_beats = beats_sent;

    target_beats = beats_sent + RandomBeats;
    now = $urandom;
    while (beats_sent < target_beats) begin
      case ($urandom_range(0, 3))
        0:       thr = '0;
        1:       thr = LevelW'(LevelMax);
        2:       thr = ThresholdReset;
        default: thr = LevelW'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       hold = '0;
        1:       hold = '1;
        2:       hold = DebounceW'($urandom_range(0, 300));
        default: hold = DebounceW'($urandom);
      endcase
      wdata = CfgDataW'($urandom);
      wdata[LevelW-1:0] = thr;
      write_reg(RegLevelThreshold, wdata);
      write_reg(RegDebounceTime, hold);
      step_max = hold / 4 + 1;
      seg_left = 0;
      phase_left = $urandom_range(60, 240);
      repeat (phase_left) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 40);
          case ($urandom_range(0, 3))
            0:       aim = int'(thr) + int'($urandom_range(1, 400));
            1:       aim = int'(thr) - int'($urandom_range(0, 400));
            2:       aim = int'($urandom_range(0, LevelMax));
            default: aim = ($urandom_range(0, 1) == 1) ? int'(LevelMax) : 0;
          endcase
        end
        seg_left--;
        if ($urandom_range(0, 15) == 0) smp = int'($urandom_range(0, LevelMax));
        else smp = aim + int'($urandom_range(0, 64)) - 32;
        if (smp < 0) smp = 0;
        if (smp > int'(LevelMax)) smp = int'(LevelMax);
        if ($urandom_range(0, 31) == 0) begin
          if ($urandom_range(0, 1) == 1) now = $urandom;
          else now = 32'hFFFF_FFFF - TimeW'($urandom_range(0, 2 * step_max));
        end else begin
          now = now + TimeW'($urandom_range(0, step_max));
        end
        beat.sample = LevelW'(smp);
        beat.now_ms = now;
        send_beat(beat, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (level_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d sensor beats (%0d directed) over %0d register writes, wrapping clock.",
             beats_sent, directed_beats, writes_done);
    $display("Checked %0d result beats, %0d with an accepted level change; %0d mismatches.",
             results_checked, changes_seen, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
